// ===== src/falru_pkg.sv =====
// ----------------------------------------------------------------------------
// falru_pkg
// Shared widths, field layout and controller-to-datapath command type for the
// fully associative LRU tag store.
// ----------------------------------------------------------------------------
package falru_pkg;

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int WAY_OUT_W   = 5;
  localparam int CNT_W       = 32;

  // Input tdata: address only
  localparam int IN_TDATA_W  = 32;

  // Output tdata: hit, way, evicted, evicted_address, hit_count, access_count
  localparam int OUT_FIELD_W = 1 + WAY_OUT_W + 1 + ADDR_W + CNT_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // input transfer: latch address, run tag compare
    logic commit;    // update state and load the output register
  } falru_cmd_t;

endpackage

// ===== src/falru_ctrl.sv =====
// ----------------------------------------------------------------------------
// falru_ctrl
// Sequencer for one access: take the input transfer, then commit the update
// as soon as the output register is free.
// ----------------------------------------------------------------------------
module falru_ctrl
  import falru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output falru_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free = !m_tvalid || m_tready;

  assign s_tready    = (state == ST_IDLE);
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.commit  = (state == ST_UPDATE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/falru_dpath.sv =====
// ----------------------------------------------------------------------------
// falru_dpath
// Tag store, valid bits, recency ranks and counters. Tags are compared in
// parallel on capture; the chosen way is updated on commit.
// ----------------------------------------------------------------------------
module falru_dpath
  import falru_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  falru_cmd_t             cmd,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int RW = $clog2(ENTRIES);
  localparam logic [RW-1:0] LAST_RANK = RW'(ENTRIES - 1);

  // storage
  logic [ADDR_W-1:0]  tags [ENTRIES];
  logic [RW-1:0]      rank [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   hits_total;
  logic [CNT_W-1:0]   accesses_total;

  // access in flight
  logic [ADDR_W-1:0]  addr_q;
  logic [ENTRIES-1:0] match_q;

  // output register
  logic                 out_hit;
  logic [WAY_OUT_W-1:0] out_way;
  logic                 out_evicted;
  logic [ADDR_W-1:0]    out_ev_addr;
  logic [CNT_W-1:0]     out_hit_count;
  logic [CNT_W-1:0]     out_acc_count;

  // update-cycle decode
  logic [ENTRIES-1:0]      invalid_vec;
  logic [ENTRIES-1:0]      low_invalid;
  logic [ENTRIES-1:0]      lru_vec;
  logic [ENTRIES-1:0]      rank_zero_vec;
  logic [ENTRIES-1:0]      sel;
  logic                    match_any;
  logic                    invalid_any;
  logic                    evict;
  logic [RW-1:0]           old_rank;
  logic [RW-1:0]           way_idx;
  logic [ADDR_W-1:0]       victim_tag;
  logic [RW+WAY_OUT_W-1:0] way_ext;
  logic [CNT_W-1:0]        hits_next;
  logic [CNT_W-1:0]        accesses_next;

  assign invalid_vec = ~valid;
  assign low_invalid = invalid_vec & (~invalid_vec + 1'b1);
  assign match_any   = |match_q;
  assign invalid_any = |invalid_vec;
  assign evict       = !match_any && !invalid_any;

  // way choice: hit way, else lowest free way, else least recently used
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_vec[i]       = (rank[i] == LAST_RANK);
      rank_zero_vec[i] = (rank[i] == '0);
    end
    if (match_any) begin
      sel = match_q;
    end else if (invalid_any) begin
      sel = low_invalid;
    end else begin
      sel = lru_vec;
    end
  end

  // one-hot select: index, old rank of chosen way, victim tag
  always_comb begin
    old_rank   = '0;
    way_idx    = '0;
    victim_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        old_rank = old_rank | rank[i];
        way_idx  = way_idx | RW'(i);
      end
      if (lru_vec[i]) victim_tag = victim_tag | tags[i];
    end
  end

  assign way_ext       = {{WAY_OUT_W{1'b0}}, way_idx};
  assign hits_next     = (match_any && hits_total != CNT_MAX) ? hits_total + 1'b1
                                                              : hits_total;
  assign accesses_next = (accesses_total != CNT_MAX) ? accesses_total + 1'b1
                                                     : accesses_total;

  // tag compare at the input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= s_tdata[ADDR_W-1:0];
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= valid[i] && (tags[i] == s_tdata[ADDR_W-1:0]);
      end
    end
  end

  // tag fill on a miss
  always_ff @(posedge clk) begin
    if (cmd.commit && !match_any) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) tags[i] <= addr_q;
      end
    end
  end

  // valid bits, ranks and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= '0;
      hits_total     <= '0;
      accesses_total <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= RW'(i);
      end
    end else if (cmd.commit) begin
      valid          <= valid | sel;
      hits_total     <= hits_next;
      accesses_total <= accesses_next;
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          rank[i] <= '0;
        end else if (rank[i] < old_rank) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit       <= match_any;
      out_way       <= way_ext[WAY_OUT_W-1:0];
      out_evicted   <= evict;
      out_ev_addr   <= evict ? victim_tag : '0;
      out_hit_count <= hits_next;
      out_acc_count <= accesses_next;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_acc_count, out_hit_count, out_ev_addr,
                    out_evicted, out_way, out_hit};

`ifndef SYNTHESIS
  // exactly one most recently used way
  a_one_mru: assert property (@(posedge clk) disable iff (rst)
    $onehot(rank_zero_vec))
    else $error("recency ranks lost their most recently used way");

  // exactly one least recently used way
  a_one_lru: assert property (@(posedge clk) disable iff (rst)
    $onehot(lru_vec))
    else $error("recency ranks lost their least recently used way");

  // valid tags are unique, so a compare never matches twice
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $onehot0(match_q))
    else $error("address matched more than one way");

  // a hit leaves the valid bits untouched
  a_hit_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && match_any |=> $stable(valid))
    else $error("valid bits changed on a hit");
`endif

endmodule

// ===== src/fully_associative_lru_cache_tags.sv =====
// ----------------------------------------------------------------------------
// fully_associative_lru_cache_tags
// Fully associative tag store with true LRU replacement and saturating
// hit and access counters.
// ----------------------------------------------------------------------------
// Each access first compares the address against all ENTRIES tags in the
// cycle it is transferred in; the update state then picks the way
// (hit way, lowest free way, or LRU way), fills it on a miss, moves it to
// the front of the recency order and loads the result register. The update
// cycle waits while the previous result is still held in the output register
// and not taken. The store is usable right after reset; there is no clearing
// pass. The way field carries the low 5 bits of the way number.
module fully_associative_lru_cache_tags
  import falru_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // input: address[31:0]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // output: hit[0], way[5:1], evicted[6], evicted_address[38:7],
  //         hit_count[70:39], access_count[102:71], zero pad[103]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  falru_cmd_t cmd;

  falru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  falru_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule
